[sv/sfcp_pkg.sv]
// Shared constants and the CRC-16/MODBUS byte update for the scope frame packer.
`default_nettype none

package sfcp_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One byte of CRC-16/MODBUS, LSB first, reflected polynomial.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = {1'b0, c[15:1]} ^ CRC_POLY;
            end else begin
                c = {1'b0, c[15:1]};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/sfcp_crc_pipe.sv]
// CRC pipeline: one register stage per sample byte, each folding its byte into the CRC.
`default_nettype none

module sfcp_crc_pipe
    import sfcp_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [16*CHANNELS-1:0]  i_data,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [16*CHANNELS-1:0]       o_data,
    output logic [15:0]                  o_crc
);

    localparam int NSTG = 2 * CHANNELS;
    localparam int DW   = 16 * CHANNELS;

    logic [DW-1:0] r_data [NSTG];
    logic [15:0]   r_crc  [NSTG];
    logic          r_vld  [NSTG];
    logic          stg_rdy [NSTG+1];

    assign stg_rdy[NSTG] = i_ready;

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        logic [DW-1:0] in_data;
        logic [15:0]   in_crc;
        logic          in_vld;
        logic [15:0]   n_crc;

        if (k == 0) begin : g_first
            assign in_data = i_data;
            assign in_crc  = CRC_INIT;
            assign in_vld  = i_valid;
        end else begin : g_next
            assign in_data = r_data[k-1];
            assign in_crc  = r_crc[k-1];
            assign in_vld  = r_vld[k-1];
        end

        assign stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        assign n_crc      = crc_byte(in_crc, in_data[8*k +: 8]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (stg_rdy[k]) begin
                r_vld[k] <= in_vld;
            end
            if (stg_rdy[k] && in_vld) begin
                r_data[k] <= in_data;
                r_crc[k]  <= n_crc;
            end
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_data[NSTG-1];
    assign o_crc   = r_crc[NSTG-1];

endmodule

`default_nettype wire

[sv/scope_frame_crc16_packer_core.sv]
// Top level: sample frame packer with CRC-16/MODBUS trailer and byte-wide output stream.
// Path: each input transaction passes through the CRC pipeline stages, then the
// serializer, then the output register, from which its frame leaves byte by byte.
// Throughput: the pipeline can accept new sample sets while a frame is still sent;
// the one-byte output port carries one byte per cycle back to back unless stalled.
// Reset: i_rst_n is synchronous and active low; it empties every pipeline stage,
// the serializer and the output register. No state is kept between frames.
`default_nettype none

module scope_frame_crc16_packer_core
    import sfcp_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input stream: one transaction is one set of channel samples.
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata: sample_0 [15:0], sample_1 [31:16], ... one 16-bit sample per channel.
    input  wire logic [16*CHANNELS-1:0]  i_s_axis_tdata,
    // Output stream: one transaction is one frame byte.
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // tdata: frame_byte [7:0].
    output logic [7:0]                   o_m_axis_tdata,
    // tlast: frame_end, set on the CRC high byte.
    output logic                         o_m_axis_tlast
);

    localparam int DW        = 16 * CHANNELS;
    localparam int FRAME_LEN = 2 * CHANNELS + 2;
    localparam int FW        = 8 * FRAME_LEN;
    localparam int LEFT_W    = $clog2(FRAME_LEN + 1);

    // The CRC pipeline runs one stage per sample byte. Its last stage holds the
    // finished frame until the serializer can take it, and earlier stages keep
    // accepting new samples while they have room.
    logic          pipe_valid;
    logic          pipe_ready;
    logic [DW-1:0] pipe_data;
    logic [15:0]   pipe_crc;

    sfcp_crc_pipe #(
        .CHANNELS (CHANNELS)
    ) u_crc_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (pipe_valid),
        .i_ready (pipe_ready),
        .o_data  (pipe_data),
        .o_crc   (pipe_crc)
    );

    // Serializer: a shift register holding the whole frame, lowest byte first,
    // and a count of bytes still to be sent.
    logic [FW-1:0]     r_frame;
    logic [LEFT_W-1:0] r_left;
    logic              r_busy;

    // Output register: separates the serializer from the downstream ready.
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic out_adv;
    logic take_byte;
    logic last_byte;
    logic load;

    assign out_adv    = !r_out_valid || i_m_axis_tready;
    assign take_byte  = r_busy && out_adv;
    assign last_byte  = (r_left == LEFT_W'(1));
    // A new frame loads when the serializer is empty, or in the same cycle that
    // its final byte moves into the output register, so frames run back to back.
    assign pipe_ready = !r_busy || (take_byte && last_byte);
    assign load       = pipe_valid && pipe_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_byte) begin
                r_out_valid <= 1'b1;
            end else if (out_adv) begin
                r_out_valid <= 1'b0;
            end

            if (load) begin
                r_busy <= 1'b1;
                r_left <= LEFT_W'(FRAME_LEN);
            end else if (take_byte) begin
                r_busy <= !last_byte;
                r_left <= r_left - LEFT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_byte) begin
            r_out_byte <= r_frame[7:0];
            r_out_last <= last_byte;
        end
        if (load) begin
            // CRC goes after the samples, low byte first.
            r_frame <= {pipe_crc, pipe_data};
        end else if (take_byte) begin
            r_frame <= {8'h00, r_frame[FW-1:8]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[sv/sfcp_checker.sv]
// Port-level checker for the scope frame packer, bound to the top level.
`default_nettype none

module sfcp_checker #(
    parameter int CHANNELS = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_data,
    input  wire logic       i_out_last
);

    localparam int FRAME_LEN = 2 * CHANNELS + 2;
    localparam int CNT_W     = $clog2(FRAME_LEN);

    logic [CNT_W-1:0] r_cnt;
    logic             out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    // Position of the next output byte within its frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (out_xfer) begin
            if (i_out_last) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Every frame is exactly FRAME_LEN bytes, flagged on its last byte.
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (i_out_last == (r_cnt == CNT_W'(FRAME_LEN - 1))))
        else $error("frame end flag out of place");

    // A frame never runs past its length without the end flag.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !i_out_last) |=> (r_cnt != CNT_W'(0)))
        else $error("frame byte count wrapped without end flag");

    // A stalled output byte holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_data) && $stable(i_out_last)))
        else $error("stalled output changed");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind scope_frame_crc16_packer_core sfcp_checker #(
    .CHANNELS (CHANNELS)
) u_sfcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata),
    .i_out_last  (o_m_axis_tlast)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the scope frame packer with its CRC-16/MODBUS trailer.
`default_nettype none

module tb_top;

    localparam int CHANNELS   = 4;
    localparam int FRAME_LEN  = 2 * CHANNELS + 2;
    localparam int N_RANDOM   = 162;
    // Longest stretch without any transaction in a correct run is a sender gap, a
    // receiver stall and the pipeline latency; this is many times that.
    localparam int STALL_LIMIT = 2000;
    // Cycles to keep watching after the last expected byte, for stray output bytes.
    localparam int DRAIN_CYCLES = 4 * FRAME_LEN;
    localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY = 16'hA001;

    // One expected output transaction: a frame byte and its end-of-frame flag.
    typedef struct packed {
        logic [7:0] octet;
        logic       eof;
    } t_frame_byte;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // sample_0 [15:0], sample_1 [31:16], sample_2 [47:32], sample_3 [63:48].
    logic [16*CHANNELS-1:0]  i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // frame_byte [7:0].
    logic [7:0]              o_m_axis_tdata;
    // frame_end.
    logic                    o_m_axis_tlast;

    logic [16*CHANNELS-1:0]  sample_set_q[$];   // sample sets waiting to be driven
    t_frame_byte             frame_byte_q[$];   // predicted bytes, oldest first
    int                      n_total = 0;       // number of sample sets in the run
    int                      n_in = 0;          // sample sets accepted so far
    int                      n_err = 0;
    int                      stall_cycles = 0;
    int                      src_gap = 0;
    int                      sink_gap = 0;
    bit                      set_taken = 1'b0;  // set at the edge, consumed by the driver
    bit                      was_taken;

    scope_frame_crc16_packer_core #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle bursts are allowed in two windows; the stretch between them and the tail
    // of the run keep both sides busy so the block also runs back to back.
    function automatic bit idle_window();
        return (n_in < 70) || (n_in >= 100 && n_in < n_total - 30);
    endfunction

    // Random sample with extra weight on the sign boundary, zero and the all-ones pattern.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Builds the ten-byte frame for one sample set: the raw two's complement patterns
    // low byte first, then the CRC-16/MODBUS of those bytes, low byte first. The CRC
    // is computed one bit at a time, which is the serial form of the byte update.
    task automatic pack_frame(input logic [16*CHANNELS-1:0] samples);
        logic [7:0]  octets[FRAME_LEN];
        logic [15:0] crc;
        logic        fb;
        t_frame_byte fbyte;
        crc = MODBUS_SEED;
        for (int n = 0; n < 2 * CHANNELS; n++) begin
            octets[n] = samples[8*n +: 8];
            for (int k = 0; k < 8; k++) begin
                fb  = crc[0] ^ octets[n][k];
                crc = crc >> 1;
                if (fb) begin
                    crc = crc ^ MODBUS_POLY;
                end
            end
        end
        octets[2*CHANNELS]     = crc[7:0];
        octets[2*CHANNELS + 1] = crc[15:8];
        for (int n = 0; n < FRAME_LEN; n++) begin
            fbyte.octet = octets[n];
            fbyte.eof   = (n == FRAME_LEN - 1);
            frame_byte_q.push_back(fbyte);
        end
    endtask

    // Input driver: presents the oldest pending sample set and holds it until the
    // transaction completes, with random gaps after accepted transactions.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            was_taken = set_taken;
            set_taken = 1'b0;
            if (was_taken) begin
                void'(sample_set_q.pop_front());
                if (idle_window() && $urandom_range(0, 2) == 0) begin
                    src_gap = $urandom_range(1, 14);
                end
            end
            if (i_s_axis_tvalid && !was_taken) begin
                // Transaction still pending: keep valid and data stable.
            end else if (src_gap > 0) begin
                src_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (sample_set_q.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= sample_set_q[0];
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure: random stall bursts, independent of the frame position,
    // so stalls land on every byte of the frame including the CRC bytes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (sink_gap == 0 && idle_window() && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 14);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: at each rising edge it records accepted input transactions, predicts
    // their frames, checks each output transaction against the oldest expected byte,
    // and runs the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pack_frame(i_s_axis_tdata);
                set_taken = 1'b1;
                n_in++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (frame_byte_q.size() == 0) begin
                    $error("unexpected output transaction: frame_byte %02h frame_end %0b",
                           o_m_axis_tdata, o_m_axis_tlast);
                    n_err++;
                end else begin
                    if (o_m_axis_tdata !== frame_byte_q[0].octet) begin
                        $error("frame_byte mismatch: expected %02h, actual %02h",
                               frame_byte_q[0].octet, o_m_axis_tdata);
                        n_err++;
                    end
                    if (o_m_axis_tlast !== frame_byte_q[0].eof) begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               frame_byte_q[0].eof, o_m_axis_tlast);
                        n_err++;
                    end
                    void'(frame_byte_q.pop_front());
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                stall_cycles = 0;
            end else if (sample_set_q.size() > 0 || frame_byte_q.size() > 0) begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial begin
        // Directed sets: field extremes, sign boundary, byte-lane and alternating
        // patterns, and a single one bit at positions 0, 5, 10 and 15 in every sample.
        sample_set_q.push_back({4{16'h0000}});
        sample_set_q.push_back({4{16'hFFFF}});
        sample_set_q.push_back({4{16'h7FFF}});
        sample_set_q.push_back({4{16'h8000}});
        sample_set_q.push_back({4{16'h0001}});
        sample_set_q.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        sample_set_q.push_back({16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000});
        sample_set_q.push_back({4{16'h00FF}});
        sample_set_q.push_back({4{16'hFF00}});
        sample_set_q.push_back({4{16'h5555}});
        sample_set_q.push_back({4{16'hAAAA}});
        sample_set_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
        sample_set_q.push_back({16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
        for (int k = 0; k < 16; k += 5) begin
            sample_set_q.push_back({4{16'(1 << k)}});
        end
        sample_set_q.push_back({16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0});
        for (int n = 0; n < N_RANDOM; n++) begin
            sample_set_q.push_back({pick_sample(), pick_sample(), pick_sample(), pick_sample()});
        end
        n_total = sample_set_q.size();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_in < n_total || frame_byte_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_err == 0 && frame_byte_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/sfcp_pkg.sv
sv/sfcp_crc_pipe.sv
sv/scope_frame_crc16_packer_core.sv
sv/sfcp_checker.sv
tb/tb_top.sv
